### rtl/assert_macros.svh
// Assertion macros used by the mailbox datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property, disabled while reset is asserted (active low).
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Clocked property that is also checked during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### rtl/spfm_pkg.sv
// Package: sizes, codes and bundle types of the socket pair mailbox.
`default_nettype none
package spfm_pkg;

  localparam int unsigned RING_DEPTH     = 4096;
  localparam int unsigned HANDLE_DEPTH   = 8;
  localparam int unsigned HANDLE_BITS    = 16;

  localparam int unsigned HANDLE_FIELD_W = 16;
  localparam int unsigned RP_W   = $clog2(RING_DEPTH);
  localparam int unsigned BCNT_W = $clog2(RING_DEPTH + 1);
  localparam int unsigned HCNT_W = $clog2(HANDLE_DEPTH + 1);
  localparam int unsigned HQ_W   = (HANDLE_BITS < HANDLE_FIELD_W) ? HANDLE_BITS
                                                                  : HANDLE_FIELD_W;

  typedef enum logic [2:0] {
    FN_SEND_BYTE   = 3'd0,
    FN_PASS_HANDLE = 3'd1,
    FN_RECV_BYTE   = 3'd2,
    FN_RECV_HANDLE = 3'd3,
    FN_CLOSE       = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_PEER_GONE = 3'd1,
    STS_FULL      = 3'd2,
    STS_EMPTY     = 3'd3,
    STS_CLOSED    = 3'd4
  } status_e;

  typedef struct packed {
    logic [2:0]                func;
    logic                      endpoint;
    logic [7:0]                data_byte;
    logic [HANDLE_FIELD_W-1:0] handle_in;
    logic                      last_of_burst;
  } req_t;

  typedef struct packed {
    logic [2:0]                status;
    logic [7:0]                read_byte;
    logic [HANDLE_FIELD_W-1:0] handle_out;
    logic                      handle_valid;
    logic                      can_read;
    logic                      can_write;
    logic                      burst_end;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;   // capture the accepted request
    logic exec;    // apply the operation to the endpoint state
    logic load;    // move the pending result into the output register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
  } dp_stat_t;

endpackage
`default_nettype wire

### rtl/spfm_ifs.sv
// Valid/ready channel interfaces for mailbox requests and results.
`default_nettype none
interface spfm_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [2:0]                           func;
  logic                                 endpoint;
  logic [7:0]                           data_byte;
  logic [spfm_pkg::HANDLE_FIELD_W-1:0]  handle_in;
  logic                                 last_of_burst;

  modport source (output valid, func, endpoint, data_byte, handle_in, last_of_burst,
                  input ready);
  modport sink   (input valid, func, endpoint, data_byte, handle_in, last_of_burst,
                  output ready);
endinterface

interface spfm_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [2:0]                           status;
  logic [7:0]                           read_byte;
  logic [spfm_pkg::HANDLE_FIELD_W-1:0]  handle_out;
  logic                                 handle_valid;
  logic                                 can_read;
  logic                                 can_write;
  logic                                 burst_end;

  modport source (output valid, status, read_byte, handle_out, handle_valid, can_read,
                  can_write, burst_end,
                  input ready);
  modport sink   (input valid, status, read_byte, handle_out, handle_valid, can_read,
                  can_write, burst_end,
                  output ready);
endinterface
`default_nettype wire

### rtl/spfm_ctrl.sv
// Controller: sequences accept, execute and result load for one request at a time.
`default_nettype none
module spfm_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  input  spfm_pkg::dp_stat_t    stat_i,
  output logic                  req_ready_o,
  output spfm_pkg::ctrl_cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        // ring read data lands this cycle; wait for room at the output
        if (stat_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

### rtl/spfm_datapath.sv
// Datapath: endpoint state, byte ring memory, handle queues and result registers.
`default_nettype none
`include "assert_macros.svh"
module spfm_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  spfm_pkg::ctrl_cmd_t  cmd_i,
  output spfm_pkg::dp_stat_t   stat_o,
  input  spfm_pkg::req_t       req_i,
  output spfm_pkg::rsp_t       rsp_o,
  output logic                 rsp_valid_o,
  input  logic                 rsp_ready_i
);

  localparam int unsigned RD     = spfm_pkg::RING_DEPTH;
  localparam int unsigned HD     = spfm_pkg::HANDLE_DEPTH;
  localparam int unsigned RP_W   = spfm_pkg::RP_W;
  localparam int unsigned BCNT_W = spfm_pkg::BCNT_W;
  localparam int unsigned HCNT_W = spfm_pkg::HCNT_W;
  localparam int unsigned HQ_W   = spfm_pkg::HQ_W;
  localparam int unsigned HFW    = spfm_pkg::HANDLE_FIELD_W;

  localparam logic [BCNT_W-1:0] RING_FULL = BCNT_W'(RD);
  localparam logic [HCNT_W-1:0] HQ_FULL   = HCNT_W'(HD);
  localparam logic [RP_W:0]     RING_SPAN = (RP_W + 1)'(RD);

  // request capture
  spfm_pkg::req_t req_q;

  // endpoint state
  logic [1:0]        open_q, open_d;
  logic [RP_W-1:0]   rp_q   [2];
  logic [RP_W-1:0]   rp_d   [2];
  logic [BCNT_W-1:0] bcnt_q [2];
  logic [BCNT_W-1:0] bcnt_d [2];
  logic [HCNT_W-1:0] hcnt_q [2];
  logic [HCNT_W-1:0] hcnt_d [2];
  logic [HQ_W-1:0]   hq_q   [2][HD];
  logic [HQ_W-1:0]   hq_d   [2][HD];

  // byte rings of both endpoints
  logic [7:0]        ring_mem [2][RD];
  logic [7:0]        ram_rdata_q;
  logic              ram_we, ram_re;

  logic              e, p;
  logic [RP_W:0]     wsum, wadj, rnext;
  logic [RP_W-1:0]   waddr;

  spfm_pkg::status_e sts;
  logic [HQ_W-1:0]   hout;
  logic              hv, can_rd, can_wr;

  // pending result, filled in the execute cycle
  logic [2:0]        pend_sts_q;
  logic [HQ_W-1:0]   pend_hout_q;
  logic              pend_hv_q, pend_cr_q, pend_cw_q, pend_burst_q, pend_rd_q;

  spfm_pkg::rsp_t    out_q;
  logic              out_valid_q;

  assign e = req_q.endpoint;
  assign p = ~req_q.endpoint;

  // tail slot of the peer ring: head + count, wrapped once
  assign wsum  = {1'b0, rp_q[p]} + (RP_W + 1)'(bcnt_q[p]);
  assign wadj  = (wsum >= RING_SPAN) ? (wsum - RING_SPAN) : wsum;
  assign waddr = wadj[RP_W-1:0];
  assign rnext = {1'b0, rp_q[e]} + (RP_W + 1)'(1);

  always_comb begin
    open_d = open_q;
    rp_d   = rp_q;
    bcnt_d = bcnt_q;
    hcnt_d = hcnt_q;
    hq_d   = hq_q;
    sts    = spfm_pkg::STS_OK;
    hout   = '0;
    hv     = 1'b0;
    ram_we = 1'b0;
    ram_re = 1'b0;
    if (cmd_i.exec) begin
      if ((req_q.func inside {[spfm_pkg::FN_SEND_BYTE:spfm_pkg::FN_CLOSE]}) && !open_q[e]) begin
        sts = spfm_pkg::STS_CLOSED;
      end else begin
        case (req_q.func)
          spfm_pkg::FN_SEND_BYTE: begin
            if (!open_q[p]) begin
              sts = spfm_pkg::STS_PEER_GONE;
            end else if (bcnt_q[p] >= RING_FULL) begin
              sts = spfm_pkg::STS_FULL;
            end else begin
              ram_we    = 1'b1;
              bcnt_d[p] = bcnt_q[p] + BCNT_W'(1);
            end
          end
          spfm_pkg::FN_PASS_HANDLE: begin
            if (!open_q[p]) begin
              sts = spfm_pkg::STS_PEER_GONE;
            end else if (hcnt_q[p] >= HQ_FULL) begin
              sts = spfm_pkg::STS_FULL;
            end else begin
              for (int i = 0; i < HD; i++) begin
                if (hcnt_q[p] == HCNT_W'(i)) begin
                  hq_d[p][i] = HQ_W'(req_q.handle_in);
                end
              end
              hcnt_d[p] = hcnt_q[p] + HCNT_W'(1);
            end
          end
          spfm_pkg::FN_RECV_BYTE: begin
            if (bcnt_q[e] == '0) begin
              sts = spfm_pkg::STS_EMPTY;
            end else begin
              ram_re    = 1'b1;
              rp_d[e]   = (rnext >= RING_SPAN) ? '0 : rnext[RP_W-1:0];
              bcnt_d[e] = bcnt_q[e] - BCNT_W'(1);
            end
          end
          spfm_pkg::FN_RECV_HANDLE: begin
            if (hcnt_q[e] == '0) begin
              sts = spfm_pkg::STS_EMPTY;
            end else begin
              hout = hq_q[e][0];
              hv   = 1'b1;
              for (int i = 0; i < HD - 1; i++) begin
                hq_d[e][i] = hq_q[e][i+1];
              end
              hcnt_d[e] = hcnt_q[e] - HCNT_W'(1);
            end
          end
          spfm_pkg::FN_CLOSE: begin
            open_d[e] = 1'b0;
            bcnt_d[e] = '0;
            rp_d[e]   = '0;
            hcnt_d[e] = '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign can_rd = open_d[e] && (bcnt_d[e] != '0);
  assign can_wr = open_d[e] && open_d[p] && (bcnt_d[p] < RING_FULL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q      <= '1;
      rp_q        <= '{default: '0};
      bcnt_q      <= '{default: '0};
      hcnt_q      <= '{default: '0};
      out_valid_q <= 1'b0;
    end else begin
      open_q <= open_d;
      rp_q   <= rp_d;
      bcnt_q <= bcnt_d;
      hcnt_q <= hcnt_d;
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hq_q <= hq_d;
    if (cmd_i.latch) begin
      req_q <= req_i;
    end
    if (cmd_i.exec) begin
      pend_sts_q   <= sts;
      pend_hout_q  <= hout;
      pend_hv_q    <= hv;
      pend_cr_q    <= can_rd;
      pend_cw_q    <= can_wr;
      pend_burst_q <= req_q.last_of_burst;
      pend_rd_q    <= ram_re;
    end
    if (cmd_i.load) begin
      out_q.status       <= pend_sts_q;
      out_q.read_byte    <= pend_rd_q ? ram_rdata_q : 8'd0;
      out_q.handle_out   <= HFW'(pend_hout_q);
      out_q.handle_valid <= pend_hv_q;
      out_q.can_read     <= pend_cr_q;
      out_q.can_write    <= pend_cw_q;
      out_q.burst_end    <= pend_burst_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      ring_mem[p][waddr] <= req_q.data_byte;
    end
    if (ram_re) begin
      ram_rdata_q <= ring_mem[e][rp_q[e]];
    end
  end

  assign stat_o.out_free = !out_valid_q || rsp_ready_i;
  assign rsp_o           = out_q;
  assign rsp_valid_o     = out_valid_q;

  `ASSERT_AT(a_close_sticky, clk_i, rst_ni, 1'b1 |=> ((open_q & ~$past(open_q)) == 2'b00), "closed endpoint reopened")
  `ASSERT_AT(a_closed_empty, clk_i, rst_ni, (open_q[0] || (bcnt_q[0] == '0 && hcnt_q[0] == '0)) && (open_q[1] || (bcnt_q[1] == '0 && hcnt_q[1] == '0)), "closed endpoint holds data")
  `ASSERT_AT(a_hv_ok, clk_i, rst_ni, out_valid_q && out_q.handle_valid |-> out_q.status == spfm_pkg::STS_OK, "handle returned with error status")
  `ASSERT_AT(a_no_overfill, clk_i, rst_ni, ram_we |-> bcnt_q[p] < RING_FULL && open_q[p], "ring write into full or closed peer")

endmodule
`default_nettype wire

### rtl/socket_pair_fifo_mailbox_unit.sv
// Top level of the socket pair mailbox: controller, datapath and channel wiring.
// Two connected endpoints, 0 and 1, each with a byte ring of spfm_pkg::RING_DEPTH
// entries and a handle queue of spfm_pkg::HANDLE_DEPTH entries. A send (byte or
// handle) from one endpoint lands in the peer's store; a receive pops the oldest
// entry of the issuing endpoint's own store; close shuts the endpoint for good and
// drops what it holds. Each request transfer yields exactly one result transfer
// with a status code and the readiness flags of the issuing endpoint after the
// operation. Requests are handled one at a time: the request port is ready only
// while the unit is idle. A result passes through an execute step that updates the
// endpoint state and issues the ring read, and then a step in which the ring
// memory's registered read data lands and the result is loaded into the output
// register; the unit is idle again in the cycle the result shows, so a new request
// is taken only once the previous one is loaded. The result sits in an output
// register; while it is stalled the unit can still take and execute one more
// request, which then waits in its last step until the output register frees.
// After reset the pair is connected with empty stores; no clearing pass is needed.
`default_nettype none
module socket_pair_fifo_mailbox_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  spfm_req_if.sink    req_i,
  spfm_rsp_if.source  rsp_o
);

  spfm_pkg::req_t      req;
  spfm_pkg::rsp_t      rsp;
  spfm_pkg::ctrl_cmd_t cmd;
  spfm_pkg::dp_stat_t  stat;
  logic                req_ready;
  logic                rsp_valid;

  // unpack the request channel
  assign req.func          = req_i.func;
  assign req.endpoint      = req_i.endpoint;
  assign req.data_byte     = req_i.data_byte;
  assign req.handle_in     = req_i.handle_in;
  assign req.last_of_burst = req_i.last_of_burst;
  assign req_i.ready       = req_ready;

  spfm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .stat_i      (stat),
    .req_ready_o (req_ready),
    .cmd_o       (cmd)
  );

  spfm_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .req_i       (req),
    .rsp_o       (rsp),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_o.ready)
  );

  // pack the result channel
  assign rsp_o.valid        = rsp_valid;
  assign rsp_o.status       = rsp.status;
  assign rsp_o.read_byte    = rsp.read_byte;
  assign rsp_o.handle_out   = rsp.handle_out;
  assign rsp_o.handle_valid = rsp.handle_valid;
  assign rsp_o.can_read     = rsp.can_read;
  assign rsp_o.can_write    = rsp.can_write;
  assign rsp_o.burst_end    = rsp.burst_end;

endmodule
`default_nettype wire
